// ===== rtl/spcs_pkg.sv =====
// Package for the scan point cluster segmenter.
// Holds field widths, register indexes, reset values, the CORDIC angle table
// and the result record; used by every module under rtl/ except spcs_queue.
`default_nettype none

package spcs_pkg;

	localparam int MAX_SCAN_DEF = 512;
	localparam int RANGE_W      = 16;
	localparam int ANGLE_W      = 16;
	localparam int OFFS_W       = 13;
	localparam int COORD_W      = 18;
	localparam int SIDX_W       = 9;
	localparam int CNT_W        = 10;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int MID_DEPTH    = 2;
	localparam int OUT_DEPTH    = 8;
	localparam int MAX_RESULTS  = 4;

	localparam logic [15:0] KGAIN = 16'd39797;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PTS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANG_START = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ANG_STEP  = 3'd4;

	localparam logic [15:0]       RST_THRESHOLD = 16'd410;
	localparam logic [CNT_W-1:0]  RST_MIN_PTS   = 10'd4;
	localparam logic [OFFS_W-1:0] RST_OFFSET_X  = 13'h1F7D;
	localparam logic [15:0]       RST_ANG_START = 16'd0;
	localparam logic [15:0]       RST_ANG_STEP  = 16'd182;

	localparam logic KIND_SEGMENT = 1'b0;
	localparam logic KIND_MARKER  = 1'b1;

	localparam logic [CNT_W-1:0] CNT_MAX = 10'd1023;

	localparam logic [21:0] ATAN_TAB [CORDIC_STEPS] = '{
		22'd2097152, 22'd1238021, 22'd654136, 22'd332050,
		22'd166669,  22'd83416,   22'd41718,  22'd20860,
		22'd10430,   22'd5215,    22'd2608,   22'd1304,
		22'd652,     22'd326,     22'd163,    22'd81
	};

	typedef struct packed {
		logic              kind;
		logic [SIDX_W-1:0] seg_start;
		logic [SIDX_W-1:0] seg_end;
		logic [CNT_W-1:0]  point_count;
		logic              last;
	} res_t;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/spcs_queue.sv =====
// Small synchronous queue in flops, one push (unless full) and one pop (unless empty) per cycle.
// Generic payload width; depth must be a power of two. No package use.
`default_nettype none

module spcs_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [WIDTH-1:0]           wdata,
	output logic                            full,
	input  wire logic                       pop,
	output logic [WIDTH-1:0]                rdata,
	output logic                            empty,
	output logic [$clog2(DEPTH+1)-1:0]      count
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= PW'(wr_ptr_q + 1'b1);
			if (do_pop)  rd_ptr_q <= PW'(rd_ptr_q + 1'b1);
			unique case ({do_push, do_pop})
				2'b10:   count_q <= CW'(count_q + 1'b1);
				2'b01:   count_q <= CW'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

`default_nettype wire

// ===== rtl/spcs_front.sv =====
// Front end: takes a range sample, tracks its scan index and turns it into
// x,y by an iterative 16-step CORDIC. Depends on spcs_pkg.
`default_nettype none

module spcs_front #(
	parameter int MAX_SCAN = spcs_pkg::MAX_SCAN_DEF,
	parameter int IW       = $clog2(MAX_SCAN)
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	input  wire logic [spcs_pkg::RANGE_W-1:0]        range_sample,
	input  wire logic                                last_sample,
	output logic                                     full,
	input  wire logic [spcs_pkg::ANGLE_W-1:0]        angle_start,
	input  wire logic [spcs_pkg::ANGLE_W-1:0]        angle_step,
	input  wire logic signed [spcs_pkg::OFFS_W-1:0]  sensor_offset_x,
	output logic                                     pt_valid,
	input  wire logic                                pt_ready,
	output logic signed [spcs_pkg::COORD_W-1:0]      pt_x,
	output logic signed [spcs_pkg::COORD_W-1:0]      pt_y,
	output logic [IW-1:0]                            pt_idx,
	output logic                                     pt_end
);
	localparam int CW = 35;
	localparam int ZW = 25;
	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_ROT  = 2'd1;
	localparam logic [1:0] F_DONE = 2'd2;

	logic [1:0]           state_q;
	logic [3:0]           it_q;
	logic [IW-1:0]        idx_q, item_idx_q;
	logic                 item_end_q;
	logic signed [CW-1:0] xc_q, yc_q;
	logic signed [ZW-1:0] z_q;

	logic                 accept, scan_end;
	logic [IW+15:0]       ang_prod;
	logic [15:0]          ang;
	logic signed [16:0]   z17, zf;
	logic                 fold;
	logic [31:0]          gain_prod;
	logic signed [CW-1:0] x_init, y_sh, x_sh;
	logic signed [ZW-1:0] z_init, z_tab;
	logic signed [CW-16:0] x_rnd, y_rnd;
	logic signed [CW-15:0] x_sum;

	assign accept   = push && !full;
	assign full     = (state_q != F_IDLE);
	assign scan_end = last_sample || (idx_q == IW'(MAX_SCAN-1));

	// sample angle and quadrant fold
	assign ang_prod = (IW+16)'(idx_q) * (IW+16)'(angle_step);
	assign ang      = angle_start + ang_prod[15:0];
	assign z17      = 17'(signed'(ang));
	assign fold     = (z17 > 17'sd16384) || (z17 < -17'sd16384);
	always_comb begin
		if (z17 > 17'sd16384)       zf = z17 - 17'sd32768;
		else if (z17 < -17'sd16384) zf = z17 + 17'sd32768;
		else                        zf = z17;
	end
	assign z_init    = ZW'(zf) <<< 8;
	assign gain_prod = 32'(range_sample) * 32'(spcs_pkg::KGAIN);
	assign x_init    = fold ? -signed'(CW'(gain_prod)) : signed'(CW'(gain_prod));

	assign x_sh  = xc_q >>> it_q;
	assign y_sh  = yc_q >>> it_q;
	assign z_tab = ZW'(spcs_pkg::ATAN_TAB[it_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			it_q    <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_ROT;
						it_q    <= '0;
						idx_q   <= scan_end ? '0 : IW'(idx_q + 1'b1);
					end
				end
				F_ROT: begin
					it_q <= 4'(it_q + 1'b1);
					if (it_q == 4'(spcs_pkg::CORDIC_STEPS-1)) state_q <= F_DONE;
				end
				F_DONE: begin
					if (pt_ready) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			xc_q       <= x_init;
			yc_q       <= '0;
			z_q        <= z_init;
			item_idx_q <= idx_q;
			item_end_q <= scan_end;
		end else if (state_q == F_ROT) begin
			if (z_q >= 0) begin
				xc_q <= xc_q - y_sh;
				yc_q <= yc_q + x_sh;
				z_q  <= z_q - z_tab;
			end else begin
				xc_q <= xc_q + y_sh;
				yc_q <= yc_q - x_sh;
				z_q  <= z_q + z_tab;
			end
		end
	end

	// round to signed Q17.0 in range units, then add the sensor offset
	assign x_rnd = (CW-15)'((xc_q + CW'(32768)) >>> 16);
	assign y_rnd = (CW-15)'((yc_q + CW'(32768)) >>> 16);
	assign x_sum = (CW-14)'(x_rnd) + (CW-14)'(sensor_offset_x);

	assign pt_valid = (state_q == F_DONE);
	assign pt_x     = spcs_pkg::COORD_W'(x_sum);
	assign pt_y     = spcs_pkg::COORD_W'(y_rnd);
	assign pt_idx   = item_idx_q;
	assign pt_end   = item_end_q;

endmodule

`default_nettype wire

// ===== rtl/spcs_back.sv =====
// Back end: distance tests between points, run bookkeeping and segment
// emission, at most one result per cycle into the result queue. Depends on spcs_pkg.
`default_nettype none

module spcs_back #(
	parameter int MAX_SCAN = spcs_pkg::MAX_SCAN_DEF,
	parameter int IW       = $clog2(MAX_SCAN)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              pt_avail,
	output logic                                   pt_take,
	input  wire logic signed [spcs_pkg::COORD_W-1:0] pt_x,
	input  wire logic signed [spcs_pkg::COORD_W-1:0] pt_y,
	input  wire logic [IW-1:0]                     pt_idx,
	input  wire logic                              pt_end,
	input  wire logic                              res_room,
	output logic                                   res_valid,
	output spcs_pkg::res_t                         res,
	input  wire logic [15:0]                       distance_threshold,
	input  wire logic [spcs_pkg::CNT_W-1:0]        min_points
);
	localparam int XW = spcs_pkg::COORD_W;
	localparam int NW = spcs_pkg::CNT_W;
	localparam int SW = spcs_pkg::SIDX_W;
	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_SQ1  = 3'd1;
	localparam logic [2:0] B_UPD  = 3'd2;
	localparam logic [2:0] B_SQ2  = 3'd3;
	localparam logic [2:0] B_CHK  = 3'd4;
	localparam logic [2:0] B_E0   = 3'd5;
	localparam logic [2:0] B_E1   = 3'd6;
	localparam logic [2:0] B_EM   = 3'd7;

	logic [2:0]           state_q;
	logic signed [XW-1:0] cur_x_q, cur_y_q, prev_x_q, prev_y_q, first_x_q, first_y_q;
	logic [IW-1:0]        idx_q, run_start_q, fre_q;
	logic                 end_q, brk_q;
	logic [NW-1:0]        run_cnt_q, frc_q;
	logic [2*XW:0]        sqa_q, sqb_q;
	spcs_pkg::res_t       p0_q, p1_q;
	logic                 p0_v_q, p1_v_q;

	logic signed [XW:0]     ax, ay, bx, by, dx, dy;
	logic signed [2*XW+1:0] sqa, sqb;
	logic [2*XW+1:0]        d2;
	logic [31:0]            t2;
	logic                   joined, pc;
	logic [NW-1:0]          merged;

	assign pt_take = (state_q == B_IDLE) && pt_avail && res_room;
	assign pc      = (cur_x_q != '0) || (cur_y_q != '0);

	// the squarer serves the neighbor test and the wrap test
	always_comb begin
		if (state_q == B_SQ1) begin
			ax = (XW+1)'(prev_x_q);  ay = (XW+1)'(prev_y_q);
		end else begin
			ax = (XW+1)'(first_x_q); ay = (XW+1)'(first_y_q);
		end
		bx = (XW+1)'(cur_x_q);
		by = (XW+1)'(cur_y_q);
	end
	assign dx  = bx - ax;
	assign dy  = by - ay;
	assign sqa = (2*XW+2)'(dx) * (2*XW+2)'(dx);
	assign sqb = (2*XW+2)'(dy) * (2*XW+2)'(dy);
	assign d2  = {1'b0, sqa_q} + {1'b0, sqb_q};
	assign t2  = 32'(distance_threshold) * 32'(distance_threshold);
	assign joined = (d2 != '0) && (d2 < (2*XW+2)'(t2));
	assign merged = spcs_pkg::sat_add(run_cnt_q, frc_q);

	function automatic logic [SW-1:0] to_sidx(input logic [IW-1:0] v);
		logic [IW+SW-1:0] w;
		w = {{SW{1'b0}}, v};
		return w[SW-1:0];
	endfunction

	function automatic spcs_pkg::res_t seg(input logic [IW-1:0] s, input logic [IW-1:0] e,
			input logic [NW-1:0] c, input logic lst);
		spcs_pkg::res_t r;
		r.kind        = spcs_pkg::KIND_SEGMENT;
		r.seg_start   = to_sidx(s);
		r.seg_end     = to_sidx(e);
		r.point_count = c;
		r.last        = lst;
		return r;
	endfunction

	always_comb begin
		res_valid = 1'b0;
		res       = p0_q;
		unique case (state_q)
			B_UPD: begin
				res_valid = (idx_q != '0) && !joined && brk_q && (run_cnt_q > min_points);
				res       = seg(run_start_q, IW'(idx_q - 1'b1), run_cnt_q, !end_q);
			end
			B_E0: begin
				res_valid = p0_v_q;
				res       = p0_q;
			end
			B_E1: begin
				res_valid = p1_v_q;
				res       = p1_q;
			end
			B_EM: begin
				res_valid         = 1'b1;
				res.kind          = spcs_pkg::KIND_MARKER;
				res.seg_start     = '0;
				res.seg_end       = '0;
				res.point_count   = '0;
				res.last          = 1'b1;
			end
			default: res_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			first_x_q   <= '0;
			first_y_q   <= '0;
			run_start_q <= '0;
			run_cnt_q   <= '0;
			fre_q       <= '0;
			frc_q       <= '0;
			brk_q       <= 1'b0;
			p0_v_q      <= 1'b0;
			p1_v_q      <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: if (pt_take) state_q <= B_SQ1;
				B_SQ1:  state_q <= B_UPD;
				B_UPD: begin
					if (idx_q == '0) begin
						first_x_q   <= cur_x_q;
						first_y_q   <= cur_y_q;
						run_start_q <= '0;
						run_cnt_q   <= NW'(pc);
						brk_q       <= 1'b0;
					end else if (joined) begin
						run_cnt_q <= spcs_pkg::sat_add(run_cnt_q, NW'(pc));
					end else begin
						if (!brk_q) begin
							fre_q <= IW'(idx_q - 1'b1);
							frc_q <= run_cnt_q;
							brk_q <= 1'b1;
						end
						run_start_q <= idx_q;
						run_cnt_q   <= NW'(pc);
					end
					prev_x_q <= cur_x_q;
					prev_y_q <= cur_y_q;
					state_q  <= end_q ? B_SQ2 : B_IDLE;
				end
				B_SQ2: state_q <= B_CHK;
				B_CHK: begin
					if (!brk_q) begin
						p0_v_q <= run_cnt_q > min_points;
						p0_q   <= seg('0, idx_q, run_cnt_q, 1'b0);
						p1_v_q <= 1'b0;
					end else if (joined) begin
						p0_v_q <= merged > min_points;
						p0_q   <= seg(run_start_q, fre_q, merged, 1'b0);
						p1_v_q <= 1'b0;
					end else begin
						p0_v_q <= frc_q > min_points;
						p0_q   <= seg('0, fre_q, frc_q, 1'b0);
						p1_v_q <= run_cnt_q > min_points;
					end
					p1_q    <= seg(run_start_q, idx_q, run_cnt_q, 1'b0);
					brk_q   <= 1'b0;
					state_q <= B_E0;
				end
				B_E0: state_q <= B_E1;
				B_E1: state_q <= B_EM;
				B_EM: state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pt_take) begin
			cur_x_q <= pt_x;
			cur_y_q <= pt_y;
			idx_q   <= pt_idx;
			end_q   <= pt_end;
		end
		sqa_q <= (2*XW+1)'(sqa);
		sqb_q <= (2*XW+1)'(sqb);
	end

endmodule

`default_nettype wire

// ===== rtl/scan_point_cluster_segmenter_unit.sv =====
// Top level of the scan point cluster segmenter: configuration registers,
// CORDIC front end, point queue, segmenting back end and result queue.
// Depends on spcs_pkg, spcs_front, spcs_queue and spcs_back.
//
// channel   direction  handshake                  payload
// input     in         push / full                range_sample, last_sample
// result    out        pop / empty                kind, seg_start, seg_end, point_count, last
// config    in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A sample occupies the CORDIC front end through load, 16 rotation steps and
// hand-off; the iterative rotator takes no new sample until the last one is handed off.
// Back end per sample: IDLE, SQ1, UPD; on a scan's last sample also SQ2, CHK, E0, E1, EM.
// full stays high while the rotator is busy or its point waits for queue space.
// The back end starts a sample only with room for four results in the result queue.
// Reset is asynchronous and returns control state, run bookkeeping and config registers to defaults.
`default_nettype none

module scan_point_cluster_segmenter_unit #(
	parameter int MAX_SCAN = spcs_pkg::MAX_SCAN_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 push,
	output logic                                      full,
	input  wire logic [spcs_pkg::RANGE_W-1:0]         range_sample,
	input  wire logic                                 last_sample,
	output logic                                      empty,
	input  wire logic                                 pop,
	output logic                                      kind,
	output logic [spcs_pkg::SIDX_W-1:0]               seg_start,
	output logic [spcs_pkg::SIDX_W-1:0]               seg_end,
	output logic [spcs_pkg::CNT_W-1:0]                point_count,
	output logic                                      last,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [spcs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [spcs_pkg::CFG_DATA_W-1:0]      cfg_data
);
	localparam int IW  = $clog2(MAX_SCAN);
	localparam int XW  = spcs_pkg::COORD_W;
	localparam int MW  = 2*XW + IW + 1;
	localparam int RW  = $bits(spcs_pkg::res_t);
	localparam int OCW = $clog2(spcs_pkg::OUT_DEPTH+1);

	logic [15:0]                        thr_q, ang_start_q, ang_step_q;
	logic [spcs_pkg::CNT_W-1:0]         min_pts_q;
	logic signed [spcs_pkg::OFFS_W-1:0] offs_x_q;

	logic                 pt_valid, pt_ready, pt_end, mid_empty, mid_full, pt_take;
	logic signed [XW-1:0] pt_x, pt_y;
	logic [IW-1:0]        pt_idx;
	logic [MW-1:0]        mid_w, mid_r;
	logic [$clog2(spcs_pkg::MID_DEPTH+1)-1:0] mid_count;
	logic                 res_valid, res_room, out_full;
	spcs_pkg::res_t       res, head;
	logic [RW-1:0]        out_r;
	logic [OCW-1:0]       out_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= spcs_pkg::RST_THRESHOLD;
			min_pts_q   <= spcs_pkg::RST_MIN_PTS;
			offs_x_q    <= spcs_pkg::RST_OFFSET_X;
			ang_start_q <= spcs_pkg::RST_ANG_START;
			ang_step_q  <= spcs_pkg::RST_ANG_STEP;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				spcs_pkg::REG_THRESHOLD: thr_q       <= cfg_data;
				spcs_pkg::REG_MIN_PTS:   min_pts_q   <= cfg_data[spcs_pkg::CNT_W-1:0];
				spcs_pkg::REG_OFFSET_X:  offs_x_q    <= cfg_data[spcs_pkg::OFFS_W-1:0];
				spcs_pkg::REG_ANG_START: ang_start_q <= cfg_data;
				spcs_pkg::REG_ANG_STEP:  ang_step_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	spcs_front #(.MAX_SCAN(MAX_SCAN), .IW(IW)) u_front (
		.clk, .arst_n, .push, .range_sample, .last_sample, .full,
		.angle_start(ang_start_q), .angle_step(ang_step_q), .sensor_offset_x(offs_x_q),
		.pt_valid, .pt_ready, .pt_x, .pt_y, .pt_idx, .pt_end
	);

	assign mid_w    = {pt_x, pt_y, pt_idx, pt_end};
	assign pt_ready = !mid_full;

	spcs_queue #(.WIDTH(MW), .DEPTH(spcs_pkg::MID_DEPTH)) u_mid (
		.clk, .arst_n, .push(pt_valid), .wdata(mid_w), .full(mid_full),
		.pop(pt_take), .rdata(mid_r), .empty(mid_empty), .count(mid_count)
	);

	assign res_room = (out_count <= OCW'(spcs_pkg::OUT_DEPTH - spcs_pkg::MAX_RESULTS));

	spcs_back #(.MAX_SCAN(MAX_SCAN), .IW(IW)) u_back (
		.clk, .arst_n,
		.pt_avail(!mid_empty), .pt_take,
		.pt_x(signed'(mid_r[MW-1 -: XW])), .pt_y(signed'(mid_r[MW-XW-1 -: XW])),
		.pt_idx(mid_r[IW:1]), .pt_end(mid_r[0]),
		.res_room, .res_valid, .res,
		.distance_threshold(thr_q), .min_points(min_pts_q)
	);

	spcs_queue #(.WIDTH(RW), .DEPTH(spcs_pkg::OUT_DEPTH)) u_out (
		.clk, .arst_n, .push(res_valid), .wdata(res), .full(out_full),
		.pop, .rdata(out_r), .empty, .count(out_count)
	);

	assign head        = spcs_pkg::res_t'(out_r);
	assign kind        = head.kind;
	assign seg_start   = head.seg_start;
	assign seg_end     = head.seg_end;
	assign point_count = head.point_count;
	assign last        = head.last;

	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !out_full)
		else $error("result written into a full result queue");

	a_mid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && mid_full |=> pt_valid)
		else $error("point dropped while the point queue was full");

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.kind == spcs_pkg::KIND_MARKER) |-> res.last)
		else $error("end of scan marker without last flag");

	a_take_with_room: assert property (@(posedge clk) disable iff (!arst_n)
		pt_take |-> !mid_empty && (mid_count != '0))
		else $error("back end took a point from an empty queue");

endmodule

`default_nettype wire

// ===== tb/sv/spcs_checker.sv =====
// Checker for the scan point cluster segmenter: watches the config, sample and
// result channels, predicts segments and markers, compares them field by field.
// Depends on spcs_pkg.
`timescale 1ns / 1ps

module spcs_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	input  wire logic                            full,
	input  wire logic [spcs_pkg::RANGE_W-1:0]    range_sample,
	input  wire logic                            last_sample,
	input  wire logic                            empty,
	input  wire logic                            pop,
	input  wire logic                            kind,
	input  wire logic [spcs_pkg::SIDX_W-1:0]     seg_start,
	input  wire logic [spcs_pkg::SIDX_W-1:0]     seg_end,
	input  wire logic [spcs_pkg::CNT_W-1:0]      point_count,
	input  wire logic                            last,
	input  wire logic                            cfg_valid,
	input  wire logic                            cfg_ready,
	input  wire logic [spcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [spcs_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                   fail_count,
	output int                                   pending,
	output int                                   seg_seen,
	output int                                   marker_seen
);
	localparam int SCAN_MAX = spcs_pkg::MAX_SCAN_DEF;

	logic [15:0]                 thr;
	logic [spcs_pkg::CNT_W-1:0]  min_pts;
	logic [spcs_pkg::OFFS_W-1:0] offs_x;
	logic [15:0]                 ang0;
	logic [15:0]                 ang_step;

	longint                      px, py, fx, fy;
	logic [spcs_pkg::SIDX_W:0]   idx;
	logic [spcs_pkg::SIDX_W:0]   rstart;
	logic [spcs_pkg::CNT_W-1:0]  rcount;
	logic [spcs_pkg::SIDX_W:0]   frun_end;
	logic [spcs_pkg::CNT_W-1:0]  frun_count;
	logic                        broke;

	spcs_pkg::res_t expected_results[$];
	spcs_pkg::res_t got;

	longint atan_step [16] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
		20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

	task automatic report(input string what, input longint exp_v, input longint got_v);
		$display("MISMATCH %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
		fail_count++;
	endtask

	function automatic void polar_to_xy(input logic [15:0] rng,
			input logic [spcs_pkg::SIDX_W:0] i, output longint ox, output longint oy);
		logic [15:0] a;
		longint z, xc, yc, dx, dy;
		a  = ang0 + 16'(i * ang_step);
		z  = longint'($signed(a));
		xc = longint'(rng) * 39797;
		yc = 0;
		if (z > 16384) begin
			z -= 32768;
			xc = -xc;
		end else if (z < -16384) begin
			z += 32768;
			xc = -xc;
		end
		z *= 256;
		for (int k = 0; k < 16; k++) begin
			dx = yc >>> k;
			dy = xc >>> k;
			if (z >= 0) begin
				xc -= dx;
				yc += dy;
				z -= atan_step[k];
			end else begin
				xc += dx;
				yc -= dy;
				z += atan_step[k];
			end
		end
		ox = ((xc + 32768) >>> 16) + longint'($signed(offs_x));
		oy = (yc + 32768) >>> 16;
	endfunction

	function automatic bit close_enough(input longint ax, input longint ay,
			input longint bx, input longint by);
		longint d2, t2;
		d2 = (bx - ax) * (bx - ax) + (by - ay) * (by - ay);
		t2 = longint'(thr) * longint'(thr);
		return d2 > 0 && d2 < t2;
	endfunction

	function automatic logic [spcs_pkg::CNT_W-1:0] count_add(
			input logic [spcs_pkg::CNT_W-1:0] a, input logic [spcs_pkg::CNT_W-1:0] b);
		int s;
		s = int'(a) + int'(b);
		return s > 1023 ? 10'd1023 : 10'(s);
	endfunction

	task automatic queue_segment(input logic k, input int s, input int e,
			input logic [spcs_pkg::CNT_W-1:0] c);
		spcs_pkg::res_t r;
		r.kind = k;
		r.seg_start = spcs_pkg::SIDX_W'(s);
		r.seg_end = spcs_pkg::SIDX_W'(e);
		r.point_count = c;
		r.last = 1'b0;
		expected_results.insert(expected_results.size(), r);
	endtask

	task automatic segment_sample(input logic [15:0] rng, input logic eos);
		longint x, y;
		logic [spcs_pkg::CNT_W-1:0] pc;
		int n0;
		n0 = expected_results.size();
		polar_to_xy(rng, idx, x, y);
		pc = (x != 0 || y != 0) ? 10'd1 : 10'd0;
		if (idx == 0) begin
			fx = x;
			fy = y;
			rstart = 0;
			rcount = pc;
			broke = 1'b0;
		end else if (close_enough(px, py, x, y)) begin
			rcount = count_add(rcount, pc);
		end else begin
			if (!broke) begin
				frun_end = idx - 1;
				frun_count = rcount;
				broke = 1'b1;
			end else if (rcount > min_pts) begin
				queue_segment(spcs_pkg::KIND_SEGMENT, rstart, idx - 1, rcount);
			end
			rstart = idx;
			rcount = pc;
		end
		px = x;
		py = y;
		if (eos || idx >= SCAN_MAX - 1) begin
			if (!broke) begin
				if (rcount > min_pts)
					queue_segment(spcs_pkg::KIND_SEGMENT, 0, idx, rcount);
			end else if (close_enough(x, y, fx, fy)) begin
				if (count_add(rcount, frun_count) > min_pts)
					queue_segment(spcs_pkg::KIND_SEGMENT, rstart, frun_end,
						count_add(rcount, frun_count));
			end else begin
				if (frun_count > min_pts)
					queue_segment(spcs_pkg::KIND_SEGMENT, 0, frun_end, frun_count);
				if (rcount > min_pts)
					queue_segment(spcs_pkg::KIND_SEGMENT, rstart, idx, rcount);
			end
			queue_segment(spcs_pkg::KIND_MARKER, 0, 0, 0);
			idx = 0;
			broke = 1'b0;
		end else begin
			idx++;
		end
		if (expected_results.size() > n0)
			expected_results[expected_results.size() - 1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr = spcs_pkg::RST_THRESHOLD;
			min_pts = spcs_pkg::RST_MIN_PTS;
			offs_x = spcs_pkg::RST_OFFSET_X;
			ang0 = spcs_pkg::RST_ANG_START;
			ang_step = spcs_pkg::RST_ANG_STEP;
			px = 0; py = 0; fx = 0; fy = 0;
			idx = 0; rstart = 0; rcount = 0; frun_end = 0; frun_count = 0;
			broke = 1'b0;
			expected_results.delete();
			fail_count = 0;
			seg_seen = 0;
			marker_seen = 0;
		end else begin
			// compare before predicting: a result cannot come out in the same cycle
			if (pop && !empty) begin
				got = '{kind, seg_start, seg_end, point_count, last};
				if (expected_results.size() == 0) begin
					report("unexpected result", 0, 1);
				end else begin
					spcs_pkg::res_t e;
					e = expected_results.pop_front();
					if (got.kind != e.kind) report("kind", e.kind, got.kind);
					if (got.seg_start != e.seg_start)
						report("seg_start", e.seg_start, got.seg_start);
					if (got.seg_end != e.seg_end) report("seg_end", e.seg_end, got.seg_end);
					if (got.point_count != e.point_count)
						report("point_count", e.point_count, got.point_count);
					if (got.last != e.last) report("last", e.last, got.last);
				end
				if (kind == spcs_pkg::KIND_MARKER) marker_seen++;
				else seg_seen++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					spcs_pkg::REG_THRESHOLD: thr = cfg_data;
					spcs_pkg::REG_MIN_PTS:   min_pts = cfg_data[spcs_pkg::CNT_W-1:0];
					spcs_pkg::REG_OFFSET_X:  offs_x = cfg_data[spcs_pkg::OFFS_W-1:0];
					spcs_pkg::REG_ANG_START: ang0 = cfg_data;
					spcs_pkg::REG_ANG_STEP:  ang_step = cfg_data;
					default: ;
				endcase
			end
			if (push && !full)
				segment_sample(range_sample, last_sample);
		end
	end

	assign pending = expected_results.size();

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the segmenter testbench: clock, reset, sample and config stimulus,
// random idling phases and the verdict. Depends on spcs_pkg, spcs_checker and the unit.
`timescale 1ns / 1ps

module tb_top;

	localparam longint CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [spcs_pkg::RANGE_W-1:0] range_sample = '0;
	logic last_sample = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic kind;
	logic [spcs_pkg::SIDX_W-1:0] seg_start, seg_end;
	logic [spcs_pkg::CNT_W-1:0] point_count;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [spcs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [spcs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count, pending, seg_seen, marker_seen;
	int push_idle_pct = 0;
	int pop_stall_pct = 0;
	int samples_sent = 0;
	longint cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	scan_point_cluster_segmenter_unit dut (.*);

	spcs_checker u_checker (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("scan_point_cluster_segmenter_unit test failed");
			$finish;
		end
	end

	// result side stalls on its own
	always @(posedge clk)
		pop <= ($urandom_range(99) >= pop_stall_pct);

	// hold valid for the accepting edge, then drop it
	task automatic write_reg(input logic [spcs_pkg::CFG_IDX_W-1:0] i, input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= i;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// push stays high after the accepting edge; the next idle cycle or drain drops it
	task automatic send_sample(input logic [15:0] r, input logic eos);
		while ($urandom_range(99) < push_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		range_sample <= r;
		last_sample <= eos;
		@(posedge clk);
		while (full) @(posedge clk);
		samples_sent++;
	endtask

	task automatic drain;
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// smooth wall with a few jumps and origin points, random length
	task automatic send_scan(input int len, input int jump_pct);
		logic [15:0] r;
		r = 16'($urandom_range(65535));
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < jump_pct) r = 16'($urandom);
			else if ($urandom_range(99) < 3) r = 16'd0;
			else r = r + 16'($urandom_range(60)) - 16'd30;
			send_sample(r, i == len - 1);
		end
	endtask

	task automatic run_phase(input int idle, input int stall, input int scans);
		push_idle_pct = idle;
		pop_stall_pct = stall;
		for (int s = 0; s < scans; s++)
			send_scan($urandom_range(2, 30), $urandom_range(2, 20));
		drain();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, origin points, one-sample scan, no-break scan
		send_sample(16'd0, 1'b1);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'd0, 1'b0);
		send_sample(16'hFFFF, 1'b1);
		for (int i = 0; i < 8; i++) send_sample(16'd4096, i == 7);
		drain();
		write_reg(spcs_pkg::REG_MIN_PTS, 16'd0);
		write_reg(spcs_pkg::REG_ANG_STEP, 16'd0);
		write_reg(spcs_pkg::REG_OFFSET_X, 16'd0);
		for (int i = 0; i < 6; i++) send_sample(16'(1000 + (i % 3) * 900), i == 5);
		drain();
		// ends connect: step around a full turn; then a zero threshold, so no points join
		write_reg(spcs_pkg::REG_ANG_STEP, 16'd8192);
		write_reg(spcs_pkg::REG_THRESHOLD, 16'hFFFF);
		for (int i = 0; i < 8; i++) send_sample(16'd2000, i == 7);
		drain();
		write_reg(spcs_pkg::REG_THRESHOLD, 16'd0);
		write_reg(spcs_pkg::REG_ANG_START, 16'hFFFF);
		write_reg(spcs_pkg::REG_OFFSET_X, 16'h1000);
		send_sample(16'd300, 1'b0);
		send_sample(16'd300, 1'b1);
		drain();

		write_reg(spcs_pkg::REG_ANG_START, 16'd0);
		write_reg(spcs_pkg::REG_MIN_PTS, 16'd2);
		write_reg(spcs_pkg::REG_THRESHOLD, 16'd410);
		write_reg(spcs_pkg::REG_OFFSET_X, 16'h1F7D);
		write_reg(spcs_pkg::REG_ANG_STEP, 16'd182);
		run_phase(0, 0, 6);
		write_reg(spcs_pkg::REG_THRESHOLD, 16'd1200);
		write_reg(spcs_pkg::REG_ANG_START, 16'($urandom));
		write_reg(spcs_pkg::REG_ANG_STEP, 16'd2000);
		run_phase(76, 0, 6);
		write_reg(spcs_pkg::REG_MIN_PTS, 16'd1);
		write_reg(spcs_pkg::REG_ANG_STEP, 16'hFFFF);
		write_reg(spcs_pkg::REG_OFFSET_X, 16'h1000);
		run_phase(0, 76, 6);
		write_reg(spcs_pkg::REG_MIN_PTS, 16'd0);
		write_reg(spcs_pkg::REG_THRESHOLD, 16'd3000);
		write_reg(spcs_pkg::REG_ANG_STEP, 16'd700);
		run_phase(24, 24, 6);

		$display("sent %0d samples; checked %0d segments and %0d scan markers",
			samples_sent, seg_seen, marker_seen);
		if (fail_count == 0)
			$display("scan_point_cluster_segmenter_unit test passed");
		else
			$display("scan_point_cluster_segmenter_unit test failed");
		$finish;
	end

endmodule
